[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property checked on every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[design/eadsr_pkg.sv]
// ----------------------------------------------------------------------------
// eadsr_pkg
// Types and constants of the exponential ADSR envelope core.
// ----------------------------------------------------------------------------
`default_nettype none

package eadsr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int RATE_BITS     = 16;

    // register reset values, levels given at 16 fractional bits
    localparam logic [RATE_BITS-1:0] ATTACK_RATE_RST  = 16'd4063;
    localparam logic [RATE_BITS-1:0] DECAY_RATE_RST   = 16'd26;
    localparam logic [RATE_BITS-1:0] RELEASE_RATE_RST = 16'd31;
    localparam logic [63:0]          SUSTAIN_RST_Q16  = 64'd40632;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_NOTE_ON  = 2'd1,
        KIND_NOTE_OFF = 2'd2,
        KIND_RESET    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_ATTACK_RATE   = 2'd0,
        CFG_DECAY_RATE    = 2'd1,
        CFG_RELEASE_RATE  = 2'd2,
        CFG_SUSTAIN_LEVEL = 2'd3
    } cfg_index_t;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_ATTACK  = 5'b00010,
        PH_DECAY   = 5'b00100,
        PH_SUSTAIN = 5'b01000,
        PH_RELEASE = 5'b10000
    } phase_t;

endpackage

`default_nettype wire

[design/exponential_adsr_envelope_core.sv]
// ----------------------------------------------------------------------------
// exponential_adsr_envelope_core
// Exponential ADSR envelope: one level and active flag per request.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake          payload (lowest bit first)
//   s_*       in   s_tvalid/s_tready  tuser: kind[1:0]; tdata: retrigger[0]
//   m_*       out  m_tvalid/m_tready  tdata: level[FRAC_BITS:0], active, zero pad
//   cfg_*     in   cfg_we             cfg_index selects register, cfg_data value
//
// One request per cycle sustained while the output is not stalled; m_tvalid is
// registered and rises once a request has passed the input register.
// The request is captured in an input register; from there one multiply
// (level distance times rate) and the phase update feed the result register
// and the envelope state together.
// Reset (async, rst_n low) empties both stages, sets phase idle, level zero and
// loads the default rates and sustain level.
// A stalled output holds the input stage; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module exponential_adsr_envelope_core #(
    parameter int FRAC_BITS = eadsr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // request stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // retrigger[0], zero pad
    input  wire logic [1:0]           s_tuser,   // kind[1:0]
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [((FRAC_BITS+2+7)/8)*8-1:0] m_tdata, // level, active, zero pad
    // configuration
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [((FRAC_BITS+1 > eadsr_pkg::RATE_BITS) ? FRAC_BITS+1
                       : eadsr_pkg::RATE_BITS)-1:0] cfg_data
);
    import eadsr_pkg::*;

    localparam int LW  = FRAC_BITS + 1;                 // level width
    localparam int OW  = ((FRAC_BITS + 2 + 7) / 8) * 8; // result tdata width
    localparam int PW  = LW + RATE_BITS;                // product width

    localparam logic [63:0] ONE64      = 64'd1 << FRAC_BITS;
    localparam logic [63:0] ATTACK64   = (64'd999 * ONE64 + 64'd500) / 64'd1000;
    localparam logic [63:0] NEAR64     = (ONE64 + 64'd5000) / 64'd10000;
    localparam logic [63:0] SUS_RST64  = (SUSTAIN_RST_Q16 * ONE64) / 64'd65536;

    localparam logic [LW-1:0] ONE_LVL     = ONE64[LW-1:0];
    localparam logic [LW-1:0] ATTACK_DONE = ATTACK64[LW-1:0];
    localparam logic [LW-1:0] NEAR_LVL    = NEAR64[LW-1:0];
    localparam logic [LW-1:0] SUS_RST     = SUS_RST64[LW-1:0];

    // configuration registers
    logic [RATE_BITS-1:0] attack_rate_reg;
    logic [RATE_BITS-1:0] decay_rate_reg;
    logic [RATE_BITS-1:0] release_rate_reg;
    logic [LW-1:0]        sustain_level_reg;

    // envelope state
    phase_t        phase_reg, phase_next;
    logic [LW-1:0] level_reg, level_next;

    // input stage
    logic  in_valid_reg;
    kind_t in_kind_reg;
    logic  in_retrig_reg;

    // result stage
    logic          out_valid_reg;
    logic [LW-1:0] out_level_reg, out_level_next;
    logic          out_active_reg;

    logic advance;

    // shared exponential step
    logic [LW-1:0]        sus_tgt;
    logic [LW-1:0]        cfg_sus;
    logic [LW-1:0]        tgt_sel;
    logic [RATE_BITS-1:0] rate_sel;
    logic [LW-1:0]        diff;
    logic [PW-1:0]        prod;
    logic [LW-1:0]        mag;
    logic [LW-1:0]        stepped;
    logic [LW-1:0]        sus_gap;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    assign sus_tgt = (sustain_level_reg > ONE_LVL) ? ONE_LVL : sustain_level_reg;
    assign cfg_sus = (cfg_data[LW-1:0] > ONE_LVL) ? ONE_LVL : cfg_data[LW-1:0];

    // target and coefficient of the current segment
    always_comb
    begin
        tgt_sel  = '0;
        rate_sel = release_rate_reg;
        unique case (phase_reg)
            PH_ATTACK:
            begin
                tgt_sel  = ONE_LVL;
                rate_sel = attack_rate_reg;
            end
            PH_DECAY:
            begin
                tgt_sel  = sus_tgt;
                rate_sel = decay_rate_reg;
            end
            default:
            begin
                tgt_sel  = '0;
                rate_sel = release_rate_reg;
            end
        endcase
    end

    // |target - level| * rate >> 16, at least one LSB
    always_comb
    begin
        diff = (tgt_sel > level_reg) ? (tgt_sel - level_reg) : (level_reg - tgt_sel);
        prod = PW'(diff) * PW'(rate_sel);
        mag  = prod[PW-1:RATE_BITS];
        if (mag == '0)
        begin
            mag = LW'(1);
        end
        if (tgt_sel == level_reg)
        begin
            stepped = level_reg;
        end
        else if (tgt_sel > level_reg)
        begin
            stepped = level_reg + mag;
        end
        else
        begin
            stepped = level_reg - mag;
        end
        sus_gap = (stepped > sus_tgt) ? (stepped - sus_tgt) : (sus_tgt - stepped);
    end

    // phase and level update for the request in the input stage
    always_comb
    begin
        phase_next = phase_reg;
        level_next = level_reg;
        unique case (in_kind_reg)
            KIND_TICK:
            begin
                unique case (phase_reg)
                    PH_ATTACK:
                    begin
                        level_next = stepped;
                        if (stepped >= ATTACK_DONE)
                        begin
                            level_next = ONE_LVL;
                            phase_next = PH_DECAY;
                        end
                    end
                    PH_DECAY:
                    begin
                        level_next = stepped;
                        if (sus_gap <= NEAR_LVL)
                        begin
                            level_next = sus_tgt;
                            phase_next = PH_SUSTAIN;
                        end
                    end
                    PH_SUSTAIN:
                    begin
                        level_next = sus_tgt;
                    end
                    PH_RELEASE:
                    begin
                        level_next = stepped;
                        if (stepped <= NEAR_LVL)
                        begin
                            level_next = '0;
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        level_next = '0;
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            KIND_NOTE_ON:
            begin
                if (in_retrig_reg)
                begin
                    level_next = '0;
                end
                phase_next = PH_ATTACK;
            end
            KIND_NOTE_OFF:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    phase_next = PH_RELEASE;
                end
            end
            default:
            begin
                level_next = '0;
                phase_next = PH_IDLE;
            end
        endcase

        // an idle tick reports zero
        if (phase_next == PH_IDLE && in_kind_reg == KIND_TICK)
        begin
            out_level_next = '0;
        end
        else
        begin
            out_level_next = level_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_rate_reg   <= ATTACK_RATE_RST;
            decay_rate_reg    <= DECAY_RATE_RST;
            release_rate_reg  <= RELEASE_RATE_RST;
            sustain_level_reg <= SUS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ATTACK_RATE:   attack_rate_reg   <= cfg_data[RATE_BITS-1:0];
                CFG_DECAY_RATE:    decay_rate_reg    <= cfg_data[RATE_BITS-1:0];
                CFG_RELEASE_RATE:  release_rate_reg  <= cfg_data[RATE_BITS-1:0];
                CFG_SUSTAIN_LEVEL: sustain_level_reg <= cfg_data[LW-1:0];
                default:           sustain_level_reg <= sustain_level_reg;
            endcase
        end
    end

    // envelope state; a sustain write during sustain moves the level at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            level_reg <= '0;
        end
        else if (cfg_we && cfg_index_t'(cfg_index) == CFG_SUSTAIN_LEVEL
                 && phase_reg == PH_SUSTAIN)
        begin
            level_reg <= cfg_sus;
        end
        else if (in_valid_reg && advance)
        begin
            phase_reg <= phase_next;
            level_reg <= level_next;
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg   <= kind_t'(s_tuser);
            in_retrig_reg <= s_tdata[0];
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_level_reg  <= out_level_next;
            out_active_reg <= (phase_next != PH_IDLE);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OW'({out_active_reg, out_level_reg});

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `ASSERT_IMPLY(a_level_in_range, out_valid_reg, out_level_reg <= ONE_LVL, "level above one")
    `ASSERT_IMPLY(a_idle_level_zero, phase_reg == PH_IDLE, level_reg == '0, "idle with level")
    `ASSERT_NEXT(a_stall_holds_input, in_valid_reg && !advance, in_valid_reg && $stable(in_kind_reg), "input stage lost on stall")

endmodule

`default_nettype wire

[tb/tb_exponential_adsr_envelope_core.sv]
// ----------------------------------------------------------------------------
// tb_exponential_adsr_envelope_core
// Self-checking regression for the exponential ADSR envelope core.
// A request-level model tracks phase, level and registers per request and
// queues the level/active pair that every request must return. Directed
// notes cover idle, event and extreme-rate cases. Random register sets then
// drive full notes (attack, decay, sustain, release) mixed with stray events.
// Both stream sides idle in random bursts, except in the last sets.
// ----------------------------------------------------------------------------
module tb_exponential_adsr_envelope_core;

    import eadsr_pkg::*;

    localparam int          LVL_W       = 17;               // Q1.16 level
    localparam int          RES_W       = 24;               // level + active, byte padded
    localparam logic [16:0] FULL_SCALE  = 17'h10000;        // 1.0
    localparam logic [16:0] ATTACK_DONE = 17'd65470;        // 0.999 rounded
    localparam logic [16:0] NEAR_LVL    = 17'd7;            // 1e-4 rounded
    localparam int          CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic             active;
    } level_result_t;

    // ------------------------------------------------------------------------
    // DUT ports; every input starts from a known value
    // ------------------------------------------------------------------------
    logic             clk;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = 8'd0;     // retrigger[0], zero pad
    logic [1:0]       s_tuser   = 2'd0;     // kind[1:0]
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [RES_W-1:0] m_tdata;              // level[16:0], active[17], zero pad
    logic             cfg_we    = 1'b0;
    logic [1:0]       cfg_index = 2'd0;
    logic [16:0]      cfg_data  = 17'd0;

    exponential_adsr_envelope_core #(
        .FRAC_BITS(16)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Envelope model: own copy of the registers and state, starting at the
    // block's reset values.
    // ------------------------------------------------------------------------
    logic [15:0]      rate_attack  = ATTACK_RATE_RST;
    logic [15:0]      rate_decay   = DECAY_RATE_RST;
    logic [15:0]      rate_release = RELEASE_RATE_RST;
    logic [16:0]      sustain_reg  = SUSTAIN_RST_Q16[16:0];
    phase_t           track_phase  = PH_IDLE;
    logic [LVL_W-1:0] track_level  = '0;

    level_result_t    pending_levels[$];    // results owed by the block, oldest first

    // bookkeeping
    bit gaps_on  = 1'b1;                    // sender may idle
    bit stall_on = 1'b1;                    // receiver may stall
    int mismatch_count;
    int results_checked;
    int cfg_writes;
    int kind_count[4];
    int decay_entries;
    int sustain_entries;
    int release_ends;
    int cycle_count;

    // sustain values above 1.0 act as 1.0
    function automatic logic [LVL_W-1:0] sustain_goal();
        return (sustain_reg > FULL_SCALE) ? FULL_SCALE : sustain_reg;
    endfunction

    // one exponential step toward tgt; never less than one LSB unless already at tgt
    function automatic logic [LVL_W-1:0] step_toward(logic [LVL_W-1:0] cur,
                                                     logic [LVL_W-1:0] tgt,
                                                     logic [15:0] rate);
        logic [LVL_W-1:0] span;
        logic [32:0]      prod;
        logic [LVL_W-1:0] mag;
        if (cur == tgt)
            return cur;
        span = (tgt > cur) ? tgt - cur : cur - tgt;
        prod = span * rate;
        mag  = prod[32:16];
        if (mag == '0)
            mag = 17'd1;
        return (tgt > cur) ? cur + mag : cur - mag;
    endfunction

    // advance the model by one request, return what the block must answer
    function automatic level_result_t envelope_advance(kind_t k, logic rt);
        level_result_t    r;
        logic [LVL_W-1:0] goal;
        logic [LVL_W-1:0] goal_gap;
        case (k)
            KIND_TICK:
            begin
                case (track_phase)
                    PH_ATTACK:
                    begin
                        track_level = step_toward(track_level, FULL_SCALE, rate_attack);
                        if (track_level >= ATTACK_DONE)
                        begin
                            track_level = FULL_SCALE;
                            track_phase = PH_DECAY;
                            decay_entries++;
                        end
                    end
                    PH_DECAY:
                    begin
                        goal        = sustain_goal();
                        track_level = step_toward(track_level, goal, rate_decay);
                        goal_gap = (track_level > goal) ? track_level - goal
                                                        : goal - track_level;
                        if (goal_gap <= NEAR_LVL)
                        begin
                            track_level = goal;
                            track_phase = PH_SUSTAIN;
                            sustain_entries++;
                        end
                    end
                    PH_SUSTAIN:
                        track_level = sustain_goal();
                    PH_RELEASE:
                    begin
                        track_level = step_toward(track_level, '0, rate_release);
                        if (track_level <= NEAR_LVL)
                        begin
                            track_level = '0;
                            track_phase = PH_IDLE;
                            release_ends++;
                        end
                    end
                    default:
                    begin
                        track_level = '0;
                        track_phase = PH_IDLE;
                    end
                endcase
            end
            KIND_NOTE_ON:
            begin
                if (rt)
                    track_level = '0;
                track_phase = PH_ATTACK;
            end
            KIND_NOTE_OFF:
            begin
                if (track_phase != PH_IDLE)
                    track_phase = PH_RELEASE;
            end
            default:
            begin
                track_level = '0;
                track_phase = PH_IDLE;
            end
        endcase
        r.level  = (track_phase == PH_IDLE && k == KIND_TICK) ? '0 : track_level;
        r.active = (track_phase != PH_IDLE);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: optional idle burst, then hold the request until taken.
    // The model advances only on acceptance.
    // ------------------------------------------------------------------------
    task automatic send_request(input kind_t k, input logic rt);
        level_result_t owed;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {7'd0, rt};
        do
            @(posedge clk);
        while (!s_tready);
        kind_count[int'(k)]++;
        owed = envelope_advance(k, rt);
        pending_levels = {pending_levels, owed};
    endtask

    // stop requesting and wait until every owed result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // register writes only happen with nothing in flight
    task automatic write_register(input cfg_index_t idx, input logic [16:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_ATTACK_RATE:  rate_attack  = val[15:0];
            CFG_DECAY_RATE:   rate_decay   = val[15:0];
            CFG_RELEASE_RATE: rate_release = val[15:0];
            default:
            begin
                sustain_reg = val;
                // a new sustain target takes effect at once while sustaining
                if (track_phase == PH_SUSTAIN)
                    track_level = sustain_goal();
            end
        endcase
        @(posedge clk);
    endtask

    task automatic write_all(input logic [15:0] atk, input logic [15:0] dec,
                             input logic [15:0] rel, input logic [16:0] sus);
        write_register(CFG_ATTACK_RATE, {1'b0, atk});
        write_register(CFG_DECAY_RATE, {1'b0, dec});
        write_register(CFG_RELEASE_RATE, {1'b0, rel});
        write_register(CFG_SUSTAIN_LEVEL, sus);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall bursts, then field-by-field check against the
    // oldest owed result.
    // ------------------------------------------------------------------------
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        level_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_levels.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, tdata %h", $time, m_tdata);
            end
            else
            begin
                want = pending_levels.pop_front();
                results_checked++;
                if (m_tdata[16:0] !== want.level)
                begin
                    mismatch_count++;
                    $display("%0t: level mismatch, expected %0d, actual %0d",
                             $time, want.level, m_tdata[16:0]);
                end
                if (m_tdata[17] !== want.active)
                begin
                    mismatch_count++;
                    $display("%0t: active mismatch, expected %0b, actual %0b",
                             $time, want.active, m_tdata[17]);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still owed", $time, pending_levels.size());
            $display("exponential_adsr_envelope_core regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // idle handling, note off while idle, retrigger vs legato re-strike,
    // reset item, retrigger bit on non note-on requests; default registers
    task automatic test_idle_and_events();
        send_request(KIND_TICK, 1'b0);
        send_request(KIND_NOTE_OFF, 1'b1);      // ignored while idle
        send_request(KIND_RESET, 1'b1);
        send_request(KIND_NOTE_ON, 1'b1);
        send_request(KIND_TICK, 1'b1);
        send_request(KIND_TICK, 1'b0);
        send_request(KIND_NOTE_ON, 1'b0);       // re-enter attack, keep level
        send_request(KIND_TICK, 1'b0);
        send_request(KIND_NOTE_OFF, 1'b0);
        send_request(KIND_TICK, 1'b0);
        send_request(KIND_NOTE_ON, 1'b0);       // from release
        send_request(KIND_RESET, 1'b0);
        send_request(KIND_TICK, 1'b0);
    endtask

    // fastest rates: one-tick segments, decay snap to sustain, sustain above
    // full scale, sustain rewritten while sustaining
    task automatic test_fast_segments();
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 17'd30000);
        send_request(KIND_NOTE_ON, 1'b1);
        send_request(KIND_TICK, 1'b0);          // attack done -> full scale
        send_request(KIND_TICK, 1'b0);          // lands within snap range
        send_request(KIND_TICK, 1'b0);
        send_request(KIND_NOTE_OFF, 1'b0);
        send_request(KIND_TICK, 1'b0);          // release drops to idle
        write_register(CFG_SUSTAIN_LEVEL, 17'h1FFFF);
        send_request(KIND_NOTE_ON, 1'b0);
        send_request(KIND_TICK, 1'b0);
        send_request(KIND_TICK, 1'b0);
        send_request(KIND_TICK, 1'b0);
        write_register(CFG_SUSTAIN_LEVEL, 17'd20000);
        send_request(KIND_NOTE_OFF, 1'b0);
        send_request(KIND_TICK, 1'b0);
    endtask

    // zero rates still move one LSB per tick
    task automatic test_zero_rates();
        write_all(16'd0, 16'd0, 16'd0, 17'h10000);
        send_request(KIND_NOTE_ON, 1'b1);
        send_request(KIND_TICK, 1'b0);
        send_request(KIND_TICK, 1'b0);
        send_request(KIND_NOTE_OFF, 1'b0);
        send_request(KIND_TICK, 1'b0);
    endtask

    // most of the time a full note, else a few stray requests
    task automatic play_note_or_noise();
        if ($urandom_range(0, 99) < 85)
        begin
            gaps_on = stall_on && ($urandom_range(0, 9) >= 3);
            send_request(KIND_NOTE_ON, 1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 90)) send_request(KIND_TICK, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 5) == 0)
            begin
                // re-strike mid-note
                send_request(KIND_NOTE_ON, 1'($urandom_range(0, 1)));
                repeat ($urandom_range(1, 40)) send_request(KIND_TICK, 1'($urandom_range(0, 1)));
            end
            send_request(KIND_NOTE_OFF, 1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 60)) send_request(KIND_TICK, 1'($urandom_range(0, 1)));
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                send_request(kind_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
    endtask

    // random register sets, mostly fast enough for notes to run their course
    task automatic test_random_envelopes();
        int set_idx;
        int stop_at;
        logic [15:0] atk;
        logic [15:0] dec;
        logic [15:0] rel;
        logic [16:0] sus;
        for (set_idx = 0; set_idx < 10; set_idx++)
        begin
            drain();
            stall_on = (set_idx < 7);
            gaps_on  = stall_on;
            atk = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                              : 16'($urandom_range(8000, 65535));
            dec = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                              : 16'($urandom_range(10000, 65535));
            rel = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                              : 16'($urandom_range(10000, 65535));
            sus = ($urandom_range(0, 5) == 0) ? 17'($urandom_range(0, 131071))
                                              : 17'($urandom_range(0, 65536));
            write_all(atk, dec, rel, sus);
            stop_at = kind_count[0] + kind_count[1] + kind_count[2] + kind_count[3] + 100;
            while (kind_count[0] + kind_count[1] + kind_count[2] + kind_count[3] < stop_at)
                play_note_or_noise();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_and_events();
        test_fast_segments();
        test_zero_rates();
        test_random_envelopes();

        drain();
        repeat (8) @(posedge clk);

        if (pending_levels.size() != 0)
        begin
            mismatch_count++;
            $display("%0t: %0d results never arrived", $time, pending_levels.size());
        end
        $display("covered %0d ticks, %0d note-on, %0d note-off, %0d resets, %0d register writes",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3], cfg_writes);
        $display("%0d results checked; decay entered %0d times, sustain %0d, release ended %0d",
                 results_checked, decay_entries, sustain_entries, release_ends);
        if (mismatch_count == 0)
            $display("exponential_adsr_envelope_core regression: pass");
        else
            $display("exponential_adsr_envelope_core regression: fail");
        $finish;
    end

endmodule
